// ===== rtl/sha1_message_digest_top_assert.svh =====
// Assertion macros shared by the SHA-1 digest RTL.
// Both macros expect signals named clock and reset in the including module.
`ifndef SHA1_MESSAGE_DIGEST_TOP_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHA1MD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHA1MD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sha1md_pkg.sv =====
// Shared types and constants of the SHA-1 digest block.
// No dependencies; imported by sha1md_round and sha1_message_digest_top.
`default_nettype none

package sha1md_pkg;

   localparam logic [31:0] ROUND_K0 = 32'h5A827999;
   localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
   localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
   localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;

   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam logic [6:0]  ROUND_LAST  = 7'd79;
   localparam logic [6:0]  SCHED_WORDS = 7'd16;

   // Control from the sequencer to the round engine.
   typedef struct packed {
      logic        rnd_en;
      logic        shift_en;
      logic [6:0]  rnd_idx;
      logic [31:0] shift_word;
   } sha1md_ctl_type;

   // Initial chaining words.
   function automatic logic [31:0] sha1md_iv(input logic [2:0] idx);
      logic [31:0] word;
      case (idx)
         3'd0: word = 32'h67452301;
         3'd1: word = 32'hEFCDAB89;
         3'd2: word = 32'h98BADCFE;
         3'd3: word = 32'h10325476;
         3'd4: word = 32'hC3D2E1F0;
         default: word = 32'h0;
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sha1_message_digest_top.sv =====
// SHA-1 digest block: byte packing, block and chaining memories, sequencer.
// Depends on sha1md_pkg, sha1md_round and sha1_message_digest_top_assert.svh.
//
// Usage. The request channel carries one beat per message byte (req_data_byte
// with req_byte_valid high); req_end_of_message closes the message, on the
// last byte or on a beat with no byte, so an empty message can be hashed.
// Beats with neither flag set are ignored. For each closed message the
// response channel returns five beats, rsp_digest_word most significant word
// first, rsp_word_index 0 to 4, rsp_last_word on the fifth.
// Operation. Byte beats are taken only while the block is idle. The 64th byte
// of a block starts a compression (the chaining words are loaded from their
// memory, run through 80 rounds on the round engine, then added and written
// back) during which req_stall is high. Closing a message writes up to 18
// padding words into the block memory, runs one or two compressions, then
// reads the five digest words from the chaining memory, one per beat.
// The response beat sits in an output register, so the block already takes
// the next message while the last digest beat waits; a held rsp_stall only
// pauses the digest readout. Synchronous reset returns the chaining words to
// the initial values and empties the partial block.
`default_nettype none
`include "sha1_message_digest_top_assert.svh"

module sha1_message_digest_top
   import sha1md_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_end_of_message,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_ROUND = 7'b0000100,
      ST_WBACK = 7'b0001000,
      ST_PADF  = 7'b0010000,
      ST_PADZ  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } st_type;

   // What follows a compression once its chaining words are written back.
   typedef enum logic [1:0] {
      AFT_NONE   = 2'd0,
      AFT_PAD    = 2'd1,
      AFT_LEN    = 2'd2,
      AFT_DIGEST = 2'd3
   } aft_type;

   localparam logic [6:0] XFER_LAST = 7'd5;   // last step of load and writeback
   localparam logic [6:0] WORD_LAST = 7'd4;   // index of the final chaining word

   st_type         state_ff, state_in;
   aft_type        after_ff, after_in;
   logic [6:0]     cnt_ff, cnt_in;
   logic [6:0]     cnt_p1, cnt_m1;
   logic [5:0]     fill_ff, fill_in;
   logic [23:0]    acc_ff, acc_in;
   logic [63:0]    bits_ff, bits_in;
   logic           len_ff, len_in;
   logic           pend_ff, pend_in;
   logic [4:0]     chv_ff, chv_in;
   logic           chv_clr;

   logic           req_fire;
   logic           out_free;
   logic           rsp_load;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_word_ff;
   logic [2:0]     rsp_idx_ff;
   logic           rsp_last_ff;

   // Block memory: sixteen big-endian message words.
   logic [31:0]    blk_mem [16];
   logic [31:0]    blk_q_ff;
   logic           blk_we;
   logic [3:0]     blk_waddr;
   logic [31:0]    blk_wdata;
   logic [3:0]     blk_raddr;
   logic [31:0]    pad_word;

   // Chaining memory: five words; a word not written since the message
   // started reads as its initial value.
   logic [31:0]    chn_mem [5];
   logic [31:0]    chn_q_ff;
   logic           chq_iv_ff;
   logic [2:0]     chq_idx_ff;
   logic           chn_re;
   logic [2:0]     chn_raddr;
   logic           chn_we;
   logic [2:0]     chn_waddr;
   logic [31:0]    chn_wdata;
   logic [31:0]    chn_word;

   sha1md_ctl_type ctl;
   logic [31:0]    eng_head;

   sha1md_round u_round (
      .clock     (clock),
      .ctl       (ctl),
      .blk_word  (blk_q_ff),
      .head_word (eng_head)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_p1    = cnt_ff + 7'd1;
   assign cnt_m1    = cnt_ff - 7'd1;
   assign chn_word  = chq_iv_ff ? sha1md_iv(chq_idx_ff) : chn_q_ff;
   assign chn_wdata = chn_word + eng_head;

   // First padding word: the bytes of the partial word, then the pad byte.
   always_comb begin
      case (fill_ff[1:0])
         2'd0: pad_word = {PAD_BYTE, 24'h0};
         2'd1: pad_word = {acc_ff[7:0], PAD_BYTE, 16'h0};
         2'd2: pad_word = {acc_ff[15:0], PAD_BYTE, 8'h0};
         2'd3: pad_word = {acc_ff[23:0], PAD_BYTE};
         default: pad_word = {PAD_BYTE, 24'h0};
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      after_in  = after_ff;
      cnt_in    = cnt_ff;
      fill_in   = fill_ff;
      acc_in    = acc_ff;
      bits_in   = bits_ff;
      len_in    = len_ff;
      pend_in   = pend_ff;
      chv_clr   = 1'b0;
      blk_we    = 1'b0;
      blk_waddr = fill_ff[5:2];
      blk_wdata = {acc_ff, req_data_byte};
      blk_raddr = (state_ff == ST_ROUND) ? cnt_p1[3:0] : 4'd0;
      chn_re    = 1'b0;
      chn_raddr = cnt_ff[2:0];
      chn_we    = 1'b0;
      chn_waddr = cnt_m1[2:0];
      rsp_load  = 1'b0;
      ctl       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_byte_valid) begin
                  blk_we  = (fill_ff[1:0] == 2'd3);
                  acc_in  = {acc_ff[15:0], req_data_byte};
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
               end
               if (req_byte_valid && (fill_ff == 6'd63)) begin
                  state_in = ST_LOAD;
                  cnt_in   = '0;
                  after_in = req_end_of_message ? AFT_PAD : AFT_NONE;
               end else if (req_end_of_message) begin
                  state_in = ST_PADF;
               end
            end
         end
         ST_LOAD: begin
            chn_re         = (cnt_ff < XFER_LAST);
            ctl.shift_en   = (cnt_ff != 7'd0);
            ctl.shift_word = chn_word;
            if (cnt_ff == XFER_LAST) begin
               state_in = ST_ROUND;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_p1;
            end
         end
         ST_ROUND: begin
            ctl.rnd_en  = 1'b1;
            ctl.rnd_idx = cnt_ff;
            if (cnt_ff == ROUND_LAST) begin
               state_in = ST_WBACK;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_p1;
            end
         end
         ST_WBACK: begin
            chn_re       = (cnt_ff < XFER_LAST);
            chn_we       = (cnt_ff != 7'd0);
            ctl.shift_en = (cnt_ff != 7'd0);
            if (cnt_ff == XFER_LAST) begin
               cnt_in = '0;
               case (after_ff)
                  AFT_NONE: state_in = ST_IDLE;
                  AFT_PAD:  state_in = ST_PADF;
                  AFT_LEN: begin
                     state_in = ST_PADZ;
                     len_in   = 1'b1;
                  end
                  AFT_DIGEST: begin
                     state_in = ST_OUT;
                     fill_in  = '0;
                     bits_in  = '0;
                     pend_in  = 1'b0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end else begin
               cnt_in = cnt_p1;
            end
         end
         ST_PADF: begin
            blk_we    = 1'b1;
            blk_wdata = pad_word;
            if (fill_ff[5:2] == 4'd15) begin
               // No room left for the length: it goes into a block of its own.
               state_in = ST_LOAD;
               cnt_in   = '0;
               after_in = AFT_LEN;
            end else begin
               state_in = ST_PADZ;
               cnt_in   = {3'd0, fill_ff[5:2] + 4'd1};
               len_in   = (fill_ff[5:2] != 4'd14);
            end
         end
         ST_PADZ: begin
            blk_we    = 1'b1;
            blk_waddr = cnt_ff[3:0];
            blk_wdata = '0;
            if (len_ff && (cnt_ff[3:0] == 4'd14)) begin
               blk_wdata = bits_ff[63:32];
            end else if (len_ff && (cnt_ff[3:0] == 4'd15)) begin
               blk_wdata = bits_ff[31:0];
            end
            if (cnt_ff[3:0] == 4'd15) begin
               state_in = ST_LOAD;
               cnt_in   = '0;
               after_in = len_ff ? AFT_DIGEST : AFT_LEN;
            end else begin
               cnt_in = cnt_p1;
            end
         end
         ST_OUT: begin
            if (!pend_ff) begin
               chn_re  = 1'b1;
               pend_in = 1'b1;
            end else if (out_free) begin
               rsp_load = 1'b1;
               pend_in  = 1'b0;
               if (cnt_ff == WORD_LAST) begin
                  chv_clr  = 1'b1;
                  state_in = ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_p1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      chv_in = chv_ff;
      if (chv_clr) begin
         chv_in = '0;
      end else if (chn_we) begin
         chv_in[chn_waddr] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_ff     <= AFT_NONE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         bits_ff      <= '0;
         len_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         chv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         chv_ff       <= chv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (rsp_load) begin
         rsp_word_ff <= chn_word;
         rsp_idx_ff  <= cnt_ff[2:0];
         rsp_last_ff <= (cnt_ff == WORD_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_waddr] <= blk_wdata;
      end
      blk_q_ff <= blk_mem[blk_raddr];
   end

   always_ff @(posedge clock) begin
      if (chn_we) begin
         chn_mem[chn_waddr] <= chn_wdata;
      end
      if (chn_re) begin
         chn_q_ff   <= chn_mem[chn_raddr];
         chq_iv_ff  <= !chv_ff[chn_raddr];
         chq_idx_ff <= chn_raddr;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_last_word   = rsp_last_ff;

   `SHA1MD_ASSERT_NOW(a_round_no_blk_write, state_ff == ST_ROUND, !blk_we, "blk write in rounds")
   `SHA1MD_ASSERT_NOW(a_round_count, state_ff == ST_ROUND, cnt_ff <= ROUND_LAST, "round overrun")
   `SHA1MD_ASSERT_NOW(a_chn_no_collide, chn_we && chn_re, chn_waddr != chn_raddr, "chn clash")
   `SHA1MD_ASSERT_NOW(a_rsp_no_overwrite, rsp_load, out_free, "held beat overwritten")
   `SHA1MD_ASSERT_NEXT(a_digest_clears_len, state_in == ST_OUT, ~|{bits_ff, fill_ff}, "length kept")

endmodule

`default_nettype wire

// ===== rtl/sha1md_round.sv =====
// SHA-1 round engine: working words a..e and the 16-word schedule window.
// Depends on sha1md_pkg for the control struct and round constants.
`default_nettype none

module sha1md_round
   import sha1md_pkg::*;
(
   input  wire logic           clock,
   input  wire sha1md_ctl_type ctl,
   input  wire logic [31:0]    blk_word,
   output logic [31:0]         head_word
);

   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] sched_ff [16];
   logic [31:0] sched_in [16];
   logic [31:0] w_mix;
   logic [31:0] w_cur;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] nxt;

   always_comb begin
      w_mix = sched_ff[2] ^ sched_ff[7] ^ sched_ff[13] ^ sched_ff[15];
      w_cur = (ctl.rnd_idx < SCHED_WORDS) ? blk_word : {w_mix[30:0], w_mix[31]};

      if (ctl.rnd_idx < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = ROUND_K0;
      end else if (ctl.rnd_idx < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = ROUND_K1;
      end else if (ctl.rnd_idx < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = ROUND_K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = ROUND_K3;
      end

      nxt = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_cur;

      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      for (int i = 0; i < 16; i++) begin
         sched_in[i] = sched_ff[i];
      end

      if (ctl.rnd_en) begin
         a_in = nxt;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
         sched_in[0] = w_cur;
         for (int i = 1; i < 16; i++) begin
            sched_in[i] = sched_ff[i-1];
         end
      end else if (ctl.shift_en) begin
         // Words enter at e and leave at a, in chaining order.
         a_in = b_ff;
         b_in = c_ff;
         c_in = d_ff;
         d_in = e_ff;
         e_in = ctl.shift_word;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      for (int i = 0; i < 16; i++) begin
         sched_ff[i] <= sched_in[i];
      end
   end

   assign head_word = a_ff;

endmodule

`default_nettype wire

// ===== tb/sha1_message_digest_top_test.sv =====
// Self-checking testbench for sha1_message_digest_top: byte beats in, digest beats out.
// Depends on sha1md_pkg (round constants, pad byte) and the RTL under rtl/.
// A local SHA-1 predictor forms the expected digest words that the monitor checks.

module sha1_message_digest_top_test
   import sha1md_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Traffic shapes. Each request beat carries its own phase, so the phase
   // changes exactly when the first beat of the next phase goes out.
   typedef enum logic [1:0] {
      PHASE_STEADY,
      PHASE_SENDER_GAPS,
      PHASE_RECEIVER_STALLS,
      PHASE_BOTH_IDLE
   } traffic_phase_type;

   typedef struct {
      logic [7:0]        data_byte;
      logic              byte_valid;
      logic              end_of_message;
      traffic_phase_type phase;
   } msg_beat_type;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last_word;
   } digest_beat_type;

   localparam int BEATS_PER_PHASE = 72;
   localparam int DRAIN_CYCLES    = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte      = 8'h00;
   logic        req_byte_valid     = 1'b0;
   logic        req_end_of_message = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   msg_beat_type      pending_beats[$];
   digest_beat_type   digest_expected[$];
   msg_beat_type      next_beat;
   digest_beat_type   oldest_digest;
   traffic_phase_type traffic_phase = PHASE_STEADY;
   int                mismatch_count = 0;

   // Predictor state: chaining words, partial block, fill position, bit count.
   logic [31:0] chain_words [0:4];
   logic [7:0]  block_bytes [0:63];
   int          fill_pos;
   logic [63:0] msg_bits;

   sha1_message_digest_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // SHA-1 predictor
   // ------------------------------------------------------------------

   // Back to the standard initial hash values with an empty partial block.
   function automatic void restart_message();
      chain_words[0] = 32'h67452301;
      chain_words[1] = 32'hEFCDAB89;
      chain_words[2] = 32'h98BADCFE;
      chain_words[3] = 32'h10325476;
      chain_words[4] = 32'hC3D2E1F0;
      fill_pos = 0;
      msg_bits = 64'd0;
   endfunction

   // One 80-round compression of block_bytes into chain_words.
   function automatic void sha1_compress();
      logic [31:0] sched [0:79];
      logic [31:0] mix;
      logic [31:0] a, b, c, d, e, f, k, sum;
      int t;
      for (t = 0; t < 16; t++) begin
         sched[t] = {block_bytes[4*t], block_bytes[4*t+1],
                     block_bytes[4*t+2], block_bytes[4*t+3]};
      end
      for (t = 16; t < 80; t++) begin
         mix = sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16];
         sched[t] = {mix[30:0], mix[31]};
      end
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (t = 0; t < 80; t++) begin
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = ROUND_K0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = ROUND_K1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = ROUND_K2;
         end else begin
            f = b ^ c ^ d;
            k = ROUND_K3;
         end
         sum = {a[26:0], a[31:27]} + f + e + k + sched[t];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = sum;
      end
      chain_words[0] = chain_words[0] + a;
      chain_words[1] = chain_words[1] + b;
      chain_words[2] = chain_words[2] + c;
      chain_words[3] = chain_words[3] + d;
      chain_words[4] = chain_words[4] + e;
   endfunction

   // Apply one accepted request beat. A closing beat pads the message, runs
   // the last one or two compressions and queues the five digest words.
   function automatic void digest_absorb(input logic [7:0] data_byte, input logic byte_valid,
                                         input logic end_of_message);
      int pos;
      int n;
      digest_beat_type beat;
      if (byte_valid) begin
         block_bytes[fill_pos] = data_byte;
         msg_bits = msg_bits + 64'd8;
         fill_pos = (fill_pos + 1) % 64;
         if (fill_pos == 0) sha1_compress();
      end
      if (end_of_message) begin
         pos = fill_pos;
         block_bytes[pos] = PAD_BYTE;
         pos++;
         // No room for the length field: the padding spills into a second block.
         if (pos > 56) begin
            while (pos < 64) begin
               block_bytes[pos] = 8'h00;
               pos++;
            end
            sha1_compress();
            pos = 0;
         end
         while (pos < 56) begin
            block_bytes[pos] = 8'h00;
            pos++;
         end
         for (n = 0; n < 8; n++) block_bytes[56+n] = msg_bits[63-8*n -: 8];
         sha1_compress();
         for (n = 0; n < 5; n++) begin
            beat.word      = chain_words[n];
            beat.index     = 3'(n);
            beat.last_word = (n == 4);
            digest_expected.push_back(beat);
         end
         restart_message();
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------

   function automatic void push_beat(input logic [7:0] data_byte, input logic byte_valid,
                                     input logic end_of_message,
                                     input traffic_phase_type phase);
      msg_beat_type beat;
      beat.data_byte      = data_byte;
      beat.byte_valid     = byte_valid;
      beat.end_of_message = end_of_message;
      beat.phase          = phase;
      pending_beats.push_back(beat);
   endfunction

   // Queue one message of random bytes. It is closed either on its last byte
   // or by a separate end-only beat; an empty message always takes the latter.
   // Ignored beats are sprinkled in as noise. Returns the count of beats that
   // the block acts on.
   function automatic int build_message(input int len, input logic close_on_byte,
                                        input traffic_phase_type phase);
      int i;
      int used;
      logic closing;
      used = 0;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(99) < 5) push_beat(8'($urandom), 1'b0, 1'b0, phase);
         closing = close_on_byte && (i == len - 1);
         push_beat(8'($urandom), 1'b1, closing, phase);
         used++;
      end
      if (!close_on_byte || len == 0) begin
         push_beat(8'($urandom), 1'b0, 1'b1, phase);
         used++;
      end
      return used;
   endfunction

   // Mostly short messages so that many digests come back, some at the
   // padding boundaries (one versus two closing compressions, full blocks),
   // and a few longer ones, some crossing a block boundary mid-message. The last
   // message of a phase is cut to what is left of the phase's budget.
   function automatic void fill_phase(input traffic_phase_type phase);
      int used;
      int len;
      int pick;
      used = 0;
      while (used < BEATS_PER_PHASE) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            len = $urandom_range(6);
         end else if (pick < 90) begin
            case ($urandom_range(7))
               0: len = 55;
               1: len = 56;
               2: len = 57;
               3: len = 63;
               4: len = 64;
               5: len = 65;
               6: len = 119;
               default: len = 120;
            endcase
         end else begin
            len = $urandom_range(130, 7);
         end
         if (len > BEATS_PER_PHASE - used) begin
            len = BEATS_PER_PHASE - used;
         end
         used += build_message(len, 1'($urandom_range(1)), phase);
      end
   endfunction

   function automatic logic sender_gap(input traffic_phase_type phase);
      case (phase)
         PHASE_SENDER_GAPS: return $urandom_range(99) < 53;
         PHASE_BOTH_IDLE:   return $urandom_range(99) < 17;
         default:           return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stall(input traffic_phase_type phase);
      case (phase)
         PHASE_RECEIVER_STALLS: return $urandom_range(99) < 53;
         PHASE_BOTH_IDLE:       return $urandom_range(99) < 17;
         default:               return 1'b0;
      endcase
   endfunction

   // Directed beats first, then the random phases. The directed part covers
   // the empty message, closing on a byte and on an end-only beat, the byte
   // extremes, and ignored beats with either data extreme.
   initial begin
      restart_message();
      push_beat(8'hFF, 1'b0, 1'b0, PHASE_STEADY);
      push_beat(8'h00, 1'b0, 1'b1, PHASE_STEADY);
      push_beat(8'h61, 1'b1, 1'b0, PHASE_STEADY);
      push_beat(8'h62, 1'b1, 1'b0, PHASE_STEADY);
      push_beat(8'h63, 1'b1, 1'b1, PHASE_STEADY);
      push_beat(8'hFF, 1'b1, 1'b1, PHASE_STEADY);
      push_beat(8'h00, 1'b1, 1'b0, PHASE_STEADY);
      push_beat(8'hFF, 1'b0, 1'b1, PHASE_STEADY);
      push_beat(8'h00, 1'b0, 1'b0, PHASE_STEADY);
      push_beat(8'hA5, 1'b0, 1'b1, PHASE_STEADY);
      push_beat(8'h80, 1'b1, 1'b0, PHASE_STEADY);
      push_beat(8'h7F, 1'b1, 1'b1, PHASE_STEADY);
      fill_phase(PHASE_STEADY);
      fill_phase(PHASE_SENDER_GAPS);
      fill_phase(PHASE_RECEIVER_STALLS);
      fill_phase(PHASE_BOTH_IDLE);
   end

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------

   // A beat is taken at an edge where req_valid is high and req_stall low;
   // the predictor sees it at that same edge. A new beat is loaded only once
   // the current one is gone, so a stalled payload never changes, and the
   // decision to raise req_valid never looks at req_stall.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            digest_absorb(req_data_byte, req_byte_valid, req_end_of_message);
         end
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 && !sender_gap(pending_beats[0].phase)) begin
               next_beat = pending_beats.pop_front();
               req_valid          <= 1'b1;
               req_data_byte      <= next_beat.data_byte;
               req_byte_valid     <= next_beat.byte_valid;
               req_end_of_message <= next_beat.end_of_message;
               traffic_phase      <= next_beat.phase;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor
   // ------------------------------------------------------------------

   // Each accepted digest beat is checked field by field against the oldest
   // expected beat. rsp_stall is redrawn every cycle from the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_expected.size() == 0) begin
               $display("%0t: unexpected digest beat word %h index %0d last %b",
                        $time, rsp_digest_word, rsp_word_index, rsp_last_word);
               mismatch_count++;
            end else begin
               oldest_digest = digest_expected.pop_front();
               if (rsp_digest_word !== oldest_digest.word) begin
                  $display("%0t: digest_word expected %h actual %h",
                           $time, oldest_digest.word, rsp_digest_word);
                  mismatch_count++;
               end
               if (rsp_word_index !== oldest_digest.index) begin
                  $display("%0t: word_index expected %0d actual %0d",
                           $time, oldest_digest.index, rsp_word_index);
                  mismatch_count++;
               end
               if (rsp_last_word !== oldest_digest.last_word) begin
                  $display("%0t: last_word expected %b actual %b",
                           $time, oldest_digest.last_word, rsp_last_word);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= receiver_stall(traffic_phase);
      end
   end

   // ------------------------------------------------------------------
   // Reset, end of run
   // ------------------------------------------------------------------

   // After reset, wait until every beat has gone out and every digest beat
   // has come back, then watch a quiet stretch for stray responses.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || digest_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && digest_expected.size() == 0) begin
         $display("PASS sha1_message_digest_top");
      end else begin
         if (digest_expected.size() != 0) begin
            $display("%0t: %0d digest beats never arrived", $time, digest_expected.size());
         end
         $display("FAIL sha1_message_digest_top");
      end
      $finish;
   end

   // A correct run ends well before this timeout even with every stall drawn.
   initial begin
      #2000000;
      $display("%0t: timeout, %0d beats unsent, %0d digest beats outstanding",
               $time, pending_beats.size(), digest_expected.size());
      $display("FAIL sha1_message_digest_top");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sha1md_pkg.sv
rtl/sha1md_round.sv
rtl/sha1_message_digest_top.sv
tb/sha1_message_digest_top_test.sv
